// File: rtl/core/zcdp_pkg.sv
// ----------------------------------------------------------------------------
// zcdp_pkg
// Types and constants shared by the ZIP central directory parser.
// ----------------------------------------------------------------------------
package zcdp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_SKIP
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_NAME  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_SIGNATURE   = 2'd0;
  localparam logic [1:0] ERR_VAR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_FIXED_TRUNC = 2'd2;

  localparam logic [31:0] CD_SIGNATURE = 32'h0201_4b50;

  localparam int FIXED_LEN = 46;
  // bytes held in the capture line; the final byte comes straight from input
  localparam int HDR_DEPTH = FIXED_LEN - 1;

  localparam int OFF_FLAGS       = 8;
  localparam int OFF_METHOD      = 10;
  localparam int OFF_CRC         = 16;
  localparam int OFF_PACKED      = 20;
  localparam int OFF_UNPACKED    = 24;
  localparam int OFF_NAME_LEN    = 28;
  localparam int OFF_EXTRA_LEN   = 30;
  localparam int OFF_COMMENT_LEN = 32;
  localparam int OFF_LOCAL       = 42;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  name_char;
    logic [15:0] entry_flags;
    logic [15:0] entry_method;
    logic [31:0] entry_crc;
    logic [31:0] packed_size;
    logic [31:0] full_size;
    logic [31:0] local_offset;
    logic [15:0] name_length;
    logic [1:0]  error_code;
    logic        end_of_directory;
  } result_t;

endpackage

// File: rtl/core/zcdp_capture.sv
// ----------------------------------------------------------------------------
// zcdp_capture
// Shift line holding the first 45 bytes of the fixed header.
// ----------------------------------------------------------------------------
module zcdp_capture (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] data_byte,
  output logic [7:0] hdr_bytes [zcdp_pkg::HDR_DEPTH]
);

  // after 45 shifts header byte k sits at position k
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < zcdp_pkg::HDR_DEPTH - 1; i++) begin
        hdr_bytes[i] <= hdr_bytes[i+1];
      end
      hdr_bytes[zcdp_pkg::HDR_DEPTH-1] <= data_byte;
    end
  end

endmodule

// File: rtl/core/zcdp_core.sv
// ----------------------------------------------------------------------------
// zcdp_core
// Parse state, counters and result formation for one directory byte.
// ----------------------------------------------------------------------------
module zcdp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [7:0]          data_byte,
  input  logic                first_byte,
  input  logic [31:0]         dir_size,
  output logic                has_result,
  output zcdp_pkg::result_t   result
);

  zcdp_pkg::phase_t phase_r, phase_nxt, eff_phase, entry_phase, name_end_phase;
  zcdp_pkg::phase_t skip_end_phase;
  logic [5:0]  hidx_r, hidx_nxt, eff_hidx;
  logic [15:0] name_r, name_nxt, eff_name, name_dec;
  logic [16:0] skip_r, skip_nxt, eff_skip, skip_dec, ext_sum;
  logic [31:0] bc_r, bc_nxt, eff_bc, bc_inc;
  logic [33:0] need;
  logic [15:0] nlen, elen, clen;
  logic        hdr_short, hdr_last, sig_ok, need_over, bc_end;
  logic        entry_done, name_done, skip_done;
  logic        shift_en;
  logic [7:0]  hdr_bytes [zcdp_pkg::HDR_DEPTH];

  zcdp_capture u_capture (
    .clk       (clk),
    .shift_en  (shift_en),
    .data_byte (data_byte),
    .hdr_bytes (hdr_bytes)
  );

  // a first-byte mark restarts the directory before the byte is used
  always_comb begin
    eff_phase = first_byte ? zcdp_pkg::PH_HEADER : phase_r;
    eff_hidx  = first_byte ? 6'd0  : hidx_r;
    eff_name  = first_byte ? 16'd0 : name_r;
    eff_skip  = first_byte ? 17'd0 : skip_r;
    eff_bc    = first_byte ? 32'd0 : bc_r;
  end

  always_comb begin
    bc_inc    = eff_bc + 32'd1;
    bc_end    = (bc_inc >= dir_size);
    hdr_short = (eff_hidx == 6'd0) &&
                (({1'b0, eff_bc} + 33'(zcdp_pkg::FIXED_LEN)) > {1'b0, dir_size});
    hdr_last  = (eff_hidx == 6'(zcdp_pkg::FIXED_LEN - 1));
    sig_ok    = ({hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]} ==
                 zcdp_pkg::CD_SIGNATURE);
    nlen      = {hdr_bytes[zcdp_pkg::OFF_NAME_LEN+1], hdr_bytes[zcdp_pkg::OFF_NAME_LEN]};
    elen      = {hdr_bytes[zcdp_pkg::OFF_EXTRA_LEN+1], hdr_bytes[zcdp_pkg::OFF_EXTRA_LEN]};
    clen      = {hdr_bytes[zcdp_pkg::OFF_COMMENT_LEN+1],
                 hdr_bytes[zcdp_pkg::OFF_COMMENT_LEN]};
    ext_sum   = {1'b0, elen} + {1'b0, clen};
    need      = {2'b00, bc_inc} + {18'd0, nlen} + {17'd0, ext_sum};
    need_over = (need > {2'b00, dir_size});

    entry_done = (nlen == 16'd0) && (ext_sum == 17'd0) && bc_end;
    if (nlen != 16'd0)         entry_phase = zcdp_pkg::PH_NAME;
    else if (ext_sum != 17'd0) entry_phase = zcdp_pkg::PH_SKIP;
    else if (bc_end)           entry_phase = zcdp_pkg::PH_IDLE;
    else                       entry_phase = zcdp_pkg::PH_HEADER;

    name_dec  = (eff_name != 16'd0) ? eff_name - 16'd1 : eff_name;
    name_done = (eff_skip == 17'd0) && bc_end;
    if (eff_skip != 17'd0) name_end_phase = zcdp_pkg::PH_SKIP;
    else if (bc_end)       name_end_phase = zcdp_pkg::PH_IDLE;
    else                   name_end_phase = zcdp_pkg::PH_HEADER;

    skip_dec  = (eff_skip != 17'd0) ? eff_skip - 17'd1 : eff_skip;
    skip_done = (eff_name == 16'd0) && bc_end;
    if (eff_name != 16'd0) skip_end_phase = zcdp_pkg::PH_NAME;
    else if (bc_end)       skip_end_phase = zcdp_pkg::PH_IDLE;
    else                   skip_end_phase = zcdp_pkg::PH_HEADER;
  end

  assign shift_en = en && (eff_phase == zcdp_pkg::PH_HEADER) && !hdr_short;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    name_nxt  = name_r;
    skip_nxt  = skip_r;
    bc_nxt    = bc_r;
    if (en) begin
      phase_nxt = eff_phase;
      hidx_nxt  = eff_hidx;
      name_nxt  = eff_name;
      skip_nxt  = eff_skip;
      bc_nxt    = eff_bc;
      unique case (eff_phase)
        zcdp_pkg::PH_IDLE: begin
          phase_nxt = zcdp_pkg::PH_IDLE;
        end
        zcdp_pkg::PH_HEADER: begin
          if (hdr_short) begin
            phase_nxt = zcdp_pkg::PH_IDLE;
            hidx_nxt  = 6'd0;
          end else begin
            bc_nxt   = bc_inc;
            hidx_nxt = eff_hidx + 6'd1;
            if (hdr_last) begin
              hidx_nxt = 6'd0;
              if (!sig_ok || need_over) begin
                phase_nxt = zcdp_pkg::PH_IDLE;
              end else begin
                name_nxt  = nlen;
                skip_nxt  = ext_sum;
                phase_nxt = entry_phase;
              end
            end
          end
        end
        zcdp_pkg::PH_NAME: begin
          bc_nxt   = bc_inc;
          name_nxt = name_dec;
          if (name_dec == 16'd0) phase_nxt = name_end_phase;
        end
        zcdp_pkg::PH_SKIP: begin
          bc_nxt   = bc_inc;
          skip_nxt = skip_dec;
          if (skip_dec == 17'd0) phase_nxt = skip_end_phase;
        end
        default: phase_nxt = zcdp_pkg::PH_IDLE;
      endcase
    end
  end

  // result
  always_comb begin
    result     = '0;
    has_result = 1'b0;
    unique case (eff_phase)
      zcdp_pkg::PH_IDLE: begin
        has_result = 1'b0;
      end
      zcdp_pkg::PH_HEADER: begin
        if (hdr_short) begin
          has_result         = 1'b1;
          result.result_kind = zcdp_pkg::KIND_ERROR;
          result.error_code  = zcdp_pkg::ERR_FIXED_TRUNC;
        end else if (hdr_last) begin
          has_result = 1'b1;
          if (!sig_ok) begin
            result.result_kind = zcdp_pkg::KIND_ERROR;
            result.error_code  = zcdp_pkg::ERR_SIGNATURE;
          end else if (need_over) begin
            result.result_kind = zcdp_pkg::KIND_ERROR;
            result.error_code  = zcdp_pkg::ERR_VAR_TRUNC;
          end else begin
            result.result_kind      = zcdp_pkg::KIND_ENTRY;
            result.entry_flags      = {hdr_bytes[zcdp_pkg::OFF_FLAGS+1],
                                       hdr_bytes[zcdp_pkg::OFF_FLAGS]};
            result.entry_method     = {hdr_bytes[zcdp_pkg::OFF_METHOD+1],
                                       hdr_bytes[zcdp_pkg::OFF_METHOD]};
            result.entry_crc        = {hdr_bytes[zcdp_pkg::OFF_CRC+3],
                                       hdr_bytes[zcdp_pkg::OFF_CRC+2],
                                       hdr_bytes[zcdp_pkg::OFF_CRC+1],
                                       hdr_bytes[zcdp_pkg::OFF_CRC]};
            result.packed_size      = {hdr_bytes[zcdp_pkg::OFF_PACKED+3],
                                       hdr_bytes[zcdp_pkg::OFF_PACKED+2],
                                       hdr_bytes[zcdp_pkg::OFF_PACKED+1],
                                       hdr_bytes[zcdp_pkg::OFF_PACKED]};
            result.full_size        = {hdr_bytes[zcdp_pkg::OFF_UNPACKED+3],
                                       hdr_bytes[zcdp_pkg::OFF_UNPACKED+2],
                                       hdr_bytes[zcdp_pkg::OFF_UNPACKED+1],
                                       hdr_bytes[zcdp_pkg::OFF_UNPACKED]};
            // top byte of the offset is the byte arriving now
            result.local_offset     = {data_byte,
                                       hdr_bytes[zcdp_pkg::OFF_LOCAL+2],
                                       hdr_bytes[zcdp_pkg::OFF_LOCAL+1],
                                       hdr_bytes[zcdp_pkg::OFF_LOCAL]};
            result.name_length      = nlen;
            result.end_of_directory = entry_done;
          end
        end
      end
      zcdp_pkg::PH_NAME: begin
        has_result              = 1'b1;
        result.result_kind      = zcdp_pkg::KIND_NAME;
        result.name_char        = data_byte;
        result.end_of_directory = (name_dec == 16'd0) && name_done;
      end
      zcdp_pkg::PH_SKIP: begin
        if ((skip_dec == 17'd0) && skip_done) begin
          has_result              = 1'b1;
          result.result_kind      = zcdp_pkg::KIND_END;
          result.end_of_directory = 1'b1;
        end
      end
      default: has_result = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= zcdp_pkg::PH_IDLE;
      hidx_r  <= 6'd0;
      name_r  <= 16'd0;
      skip_r  <= 17'd0;
      bc_r    <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      name_r  <= name_nxt;
      skip_r  <= skip_nxt;
      bc_r    <= bc_nxt;
    end
  end

endmodule

// File: rtl/core/zip_central_directory_parser.sv
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// Byte-wide ZIP central directory header parser with entry, name, end and error output.
// ----------------------------------------------------------------------------
//  channel  ports                      handshake      word
//  in       in_dir_byte, in_first_byte in_valid/stall  one directory byte
//  out      out_result_kind ...        out_valid/stall one result
//  cfg      cfg_data                   cfg_valid/ready directory size
//
//  One byte per cycle unless a result waits on a stalled output; a taken
//  byte passes the input register, then the result register, on its way to
//  the output ports. The byte counter and length counters update per byte.
//  Synchronous active-low reset leaves the parser idle, waiting for a byte
//  marked first_byte; the header capture line is not reset.
//  A stalled result holds in the output register; bytes giving no result
//  keep flowing past it.
module zip_central_directory_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_dir_byte,
  input  logic        in_first_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_entry_flags,
  output logic [15:0] out_entry_method,
  output logic [31:0] out_entry_crc,
  output logic [31:0] out_packed_size,
  output logic [31:0] out_full_size,
  output logic [31:0] out_local_offset,
  output logic [15:0] out_name_length,
  output logic [1:0]  out_error_code,
  output logic        out_end_of_directory,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_first_r;
  logic              s1_fire, out_free, has_result;
  logic              out_valid_r;
  logic [31:0]       dir_size_r;
  zcdp_pkg::result_t core_res;
  zcdp_pkg::result_t out_res_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_size_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      dir_size_r <= cfg_data;
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && (out_free || !has_result);
  assign in_stall = s1_valid_r && !s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_dir_byte;
      s1_first_r <= in_first_byte;
    end
  end

  zcdp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (s1_fire),
    .data_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .dir_size   (dir_size_r),
    .has_result (has_result),
    .result     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result_kind      = out_res_r.result_kind;
  assign out_name_char        = out_res_r.name_char;
  assign out_entry_flags      = out_res_r.entry_flags;
  assign out_entry_method     = out_res_r.entry_method;
  assign out_entry_crc        = out_res_r.entry_crc;
  assign out_packed_size      = out_res_r.packed_size;
  assign out_full_size        = out_res_r.full_size;
  assign out_local_offset     = out_res_r.local_offset;
  assign out_name_length      = out_res_r.name_length;
  assign out_error_code       = out_res_r.error_code;
  assign out_end_of_directory = out_res_r.end_of_directory;

endmodule

// File: rtl/core/zcdp_checker.sv
// ----------------------------------------------------------------------------
// zcdp_checker
// Port-level checks on the result stream of the directory parser.
// ----------------------------------------------------------------------------
module zcdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_result_kind,
  input logic [7:0]  out_name_char,
  input logic [15:0] out_entry_flags,
  input logic [15:0] out_name_length,
  input logic [1:0]  out_error_code,
  input logic        out_end_of_directory
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
                               $stable(out_name_char))
    else $error("stalled result word changed");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == zcdp_pkg::KIND_ERROR) |->
      !out_end_of_directory && (out_error_code != 2'd3))
    else $error("error word with end flag or bad code");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == zcdp_pkg::KIND_END) |->
      out_end_of_directory && (out_name_char == 8'd0))
    else $error("directory end word malformed");

  // only entry records carry header fields
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != zcdp_pkg::KIND_ENTRY) |->
      (out_entry_flags == 16'd0) && (out_name_length == 16'd0))
    else $error("header fields on a non-entry word");

endmodule

bind zip_central_directory_parser zcdp_checker u_zcdp_checker (.*);
